FILE: hw/rtl/wfa_pkg.sv
// shared widths, register indexes and the item type passed between the
// accumulator, divider and blend stages of the weighted federated average
// no dependencies
package wfa_pkg;

    localparam int NODE_W     = 6;
    localparam int POS_W      = 12;
    localparam int WEIGHT_W   = 32;
    localparam int SUM_W      = 38;
    localparam int COUNT_W    = 7;
    localparam int ALPHA_W    = 17;
    localparam int PROD_W     = 50;
    localparam int ACC_W      = 56;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_FACTOR = 1'd1;

    // one position on its way to the output: val is the sum, later the average
    typedef struct packed {
        logic [POS_W-1:0]         pos;
        logic signed [SUM_W-1:0]  val;
        logic [COUNT_W-1:0]       count;
        logic signed [PROD_W-1:0] pa;
        logic [ALPHA_W-1:0]       beta;
    } avg_item_t;

endpackage

FILE: hw/rtl/wfa_acc.sv
// accumulator: sum memory with read-modify-write, last-write forwarding,
// and the stage that picks out last-node items for the divider
// depends on wfa_pkg
module wfa_acc #(
    parameter int MAX_WEIGHTS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [wfa_pkg::NODE_W-1:0]         s_node_number,
    input  logic [wfa_pkg::POS_W-1:0]          s_weight_position,
    input  logic signed [wfa_pkg::WEIGHT_W-1:0] s_node_weight,
    input  logic signed [wfa_pkg::WEIGHT_W-1:0] s_start_weight,
    input  logic [wfa_pkg::COUNT_W-1:0]        node_count,
    input  logic [wfa_pkg::ALPHA_W-1:0]        blend_factor,
    output logic                               out_valid,
    input  logic                               out_ready,
    output wfa_pkg::avg_item_t                 out_item
);

    localparam int AW = (MAX_WEIGHTS > 1) ? $clog2(MAX_WEIGHTS) : 1;
    localparam int SUM_W = wfa_pkg::SUM_W;
    localparam int WEIGHT_W = wfa_pkg::WEIGHT_W;
    localparam int COUNT_W = wfa_pkg::COUNT_W;

    logic [SUM_W-1:0] mem [MAX_WEIGHTS];

    logic                          s1_v_reg;
    logic [wfa_pkg::NODE_W-1:0]    s1_node_reg;
    logic [wfa_pkg::POS_W-1:0]     s1_pos_reg;
    logic [AW-1:0]                 s1_addr_reg;
    logic signed [WEIGHT_W-1:0]    s1_weight_reg;
    logic signed [WEIGHT_W-1:0]    s1_start_reg;
    logic [SUM_W-1:0]              rd_reg;

    logic                          lw_v_reg;
    logic [AW-1:0]                 lw_addr_reg;
    logic [SUM_W-1:0]              lw_data_reg;

    logic                          s2_v_reg;
    wfa_pkg::avg_item_t            s2_reg;

    logic [AW-1:0]                 s_addr;
    logic                          in_range;
    logic                          s1_move;
    logic                          s2_ready;
    logic                          wr_en;
    logic [COUNT_W-1:0]            count;
    logic [wfa_pkg::ALPHA_W-1:0]   alpha;
    logic [wfa_pkg::ALPHA_W-1:0]   beta;
    logic [SUM_W-1:0]              base;
    logic [SUM_W-1:0]              sum;
    logic                          last;
    logic signed [wfa_pkg::PROD_W-1:0] pa;

    assign s_addr   = AW'(s_weight_position);
    assign in_range = 32'(s_weight_position) < 32'(MAX_WEIGHTS);

    assign count = (node_count == '0) ? COUNT_W'(1) : node_count;
    assign alpha = (blend_factor > wfa_pkg::ALPHA_ONE) ? wfa_pkg::ALPHA_ONE : blend_factor;
    assign beta  = wfa_pkg::ALPHA_ONE - alpha;

    // the write leaving s1 at the edge this item was read is not in rd_reg yet
    assign base = (lw_v_reg && (lw_addr_reg == s1_addr_reg)) ? lw_data_reg : rd_reg;
    assign sum  = (s1_node_reg == '0)
                ? {{(SUM_W-WEIGHT_W){s1_weight_reg[WEIGHT_W-1]}}, s1_weight_reg}
                : base + {{(SUM_W-WEIGHT_W){s1_weight_reg[WEIGHT_W-1]}}, s1_weight_reg};
    assign last = ({1'b0, s1_node_reg} == (count - COUNT_W'(1)));
    assign pa   = $signed({1'b0, alpha}) * s1_start_reg;

    assign s2_ready = !s2_v_reg || out_ready;
    assign s1_move  = !s1_v_reg || !last || s2_ready;
    assign wr_en    = s1_v_reg && s1_move;
    assign s_ready  = s1_move;

    assign out_valid = s2_v_reg;
    assign out_item  = s2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            lw_v_reg <= 1'b0;
        end else begin
            if (s1_move) begin
                s1_v_reg <= s_valid && in_range;
            end
            if (s2_ready) begin
                s2_v_reg <= s1_v_reg && last;
            end
            if (wr_en) begin
                lw_v_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_move) begin
            s1_node_reg   <= s_node_number;
            s1_pos_reg    <= s_weight_position;
            s1_addr_reg   <= s_addr;
            s1_weight_reg <= s_node_weight;
            s1_start_reg  <= s_start_weight;
        end
        if (s2_ready) begin
            s2_reg.pos   <= s1_pos_reg;
            s2_reg.val   <= sum;
            s2_reg.count <= count;
            s2_reg.pa    <= pa;
            s2_reg.beta  <= beta;
        end
        if (wr_en) begin
            lw_addr_reg <= s1_addr_reg;
            lw_data_reg <= sum;
        end
    end

    // sum memory: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[s1_addr_reg] <= sum;
        end
        if (s_valid && s1_move) begin
            rd_reg <= mem[s_addr];
        end
    end

    a_accept_loads_s1: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && in_range) |=> s1_v_reg)
        else $error("accepted in-range transfer did not reach s1");

    a_dropped_not_forwarded: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_v_reg && s2_ready && !last) |=> !s2_v_reg)
        else $error("non-last item passed to the divider");

    a_s2_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (s2_v_reg && !out_ready) |=> (s2_v_reg && $stable(s2_reg)))
        else $error("stalled sum changed before transfer");

    a_write_tracked: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> (lw_v_reg && (lw_addr_reg == $past(s1_addr_reg))))
        else $error("forwarding register missed a write");

endmodule

FILE: hw/rtl/wfa_div.sv
// pipelined signed divide of the node sum by the node count, truncating
// toward zero: magnitude stage, eight quotient bits per stage, sign fix
// depends on wfa_pkg
module wfa_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  wfa_pkg::avg_item_t in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output wfa_pkg::avg_item_t out_item
);

    localparam int SUM_W     = wfa_pkg::SUM_W;
    localparam int COUNT_W   = wfa_pkg::COUNT_W;
    localparam int STEP_BITS = 8;
    localparam int STEPS     = (SUM_W + STEP_BITS - 1) / STEP_BITS;
    localparam int DIV_W     = STEPS * STEP_BITS;
    localparam int REM_W     = COUNT_W - 1;
    localparam int NST       = STEPS + 2;

    typedef struct packed {
        logic [wfa_pkg::POS_W-1:0]         pos;
        logic [DIV_W-1:0]                  work;
        logic [REM_W-1:0]                  rem;
        logic                              neg;
        logic [COUNT_W-1:0]                count;
        logic signed [wfa_pkg::PROD_W-1:0] pa;
        logic [wfa_pkg::ALPHA_W-1:0]       beta;
    } div_stage_t;

    // restoring division, quotient bits shift into the low end of work
    function automatic div_stage_t div_step(input div_stage_t s);
        div_stage_t     r;
        logic [REM_W:0] t;
        r = s;
        for (int i = 0; i < STEP_BITS; i++) begin
            t      = {r.rem, r.work[DIV_W-1]};
            r.work = {r.work[DIV_W-2:0], 1'b0};
            if (t >= r.count) begin
                t         = t - r.count;
                r.work[0] = 1'b1;
            end
            r.rem = t[REM_W-1:0];
        end
        return r;
    endfunction

    logic [NST-1:0]     v_reg;
    logic [NST-1:0]     rdy;
    div_stage_t         st_reg [NST-1];
    div_stage_t         nxt    [NST-1];
    wfa_pkg::avg_item_t out_reg;
    wfa_pkg::avg_item_t fix;
    logic [SUM_W-1:0]   mag;
    logic [SUM_W-1:0]   quo;

    always_comb begin
        rdy[NST-1] = !v_reg[NST-1] || out_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    assign in_ready = rdy[0];

    always_comb begin
        mag = in_item.val[SUM_W-1] ? SUM_W'(-in_item.val) : in_item.val;
        nxt[0].pos   = in_item.pos;
        nxt[0].work  = DIV_W'(mag);
        nxt[0].rem   = '0;
        nxt[0].neg   = in_item.val[SUM_W-1];
        nxt[0].count = in_item.count;
        nxt[0].pa    = in_item.pa;
        nxt[0].beta  = in_item.beta;
        for (int k = 1; k < NST - 1; k++) begin
            nxt[k] = div_step(st_reg[k-1]);
        end
    end

    always_comb begin
        quo        = st_reg[NST-2].work[SUM_W-1:0];
        fix.pos    = st_reg[NST-2].pos;
        fix.val    = st_reg[NST-2].neg ? -quo : quo;
        fix.count  = st_reg[NST-2].count;
        fix.pa     = st_reg[NST-2].pa;
        fix.beta   = st_reg[NST-2].beta;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (rdy[0]) begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (rdy[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < NST - 1; k++) begin
            if (rdy[k]) begin
                st_reg[k] <= nxt[k];
            end
        end
        if (rdy[NST-1]) begin
            out_reg <= fix;
        end
    end

    assign out_valid = v_reg[NST-1];
    assign out_item  = out_reg;

endmodule

FILE: hw/rtl/wfa_blend.sv
// blend of start weight and average: split multiply over three stages,
// floor shift by 16 and saturation into the output register
// depends on wfa_pkg
module wfa_blend (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  wfa_pkg::avg_item_t                  in_item,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [wfa_pkg::POS_W-1:0]           result_position,
    output logic signed [wfa_pkg::WEIGHT_W-1:0] blended_weight
);

    localparam int SUM_W    = wfa_pkg::SUM_W;
    localparam int ACC_W    = wfa_pkg::ACC_W;
    localparam int PROD_W   = wfa_pkg::PROD_W;
    localparam int ALPHA_W  = wfa_pkg::ALPHA_W;
    localparam int WEIGHT_W = wfa_pkg::WEIGHT_W;
    localparam int LO_W     = 19;
    localparam int HI_W     = SUM_W - LO_W;
    localparam int PLO_W    = ALPHA_W + LO_W;
    localparam int PHI_W    = ALPHA_W + 1 + HI_W;
    localparam int SH       = 16;
    localparam int SAT_W    = ACC_W - SH;
    localparam int NST      = 4;

    logic [NST-1:0] v_reg;
    logic [NST-1:0] rdy;

    logic [wfa_pkg::POS_W-1:0]  b1_pos_reg;
    logic signed [PROD_W-1:0]   b1_pa_reg;
    logic [ALPHA_W-1:0]         b1_beta_reg;
    logic signed [HI_W-1:0]     b1_hi_reg;
    logic [PLO_W-1:0]           b1_plo_reg;

    logic [wfa_pkg::POS_W-1:0]  b2_pos_reg;
    logic signed [ACC_W-1:0]    b2_part_reg;
    logic signed [PHI_W-1:0]    b2_phi_reg;

    logic [wfa_pkg::POS_W-1:0]  b3_pos_reg;
    logic signed [ACC_W-1:0]    b3_acc_reg;

    logic [wfa_pkg::POS_W-1:0]  pos_reg;
    logic signed [WEIGHT_W-1:0] weight_reg;

    logic [PLO_W-1:0]           plo;
    logic signed [PHI_W-1:0]    phi;
    logic signed [ACC_W-1:0]    part;
    logic signed [ACC_W-1:0]    acc;
    logic signed [SAT_W-1:0]    shifted;
    logic                       fits;
    logic signed [WEIGHT_W-1:0] sat;

    always_comb begin
        rdy[NST-1] = !v_reg[NST-1] || out_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    assign in_ready = rdy[0];

    // average = hi * 2^19 + lo, lo taken unsigned
    assign plo  = in_item.beta * in_item.val[LO_W-1:0];
    assign phi  = $signed({1'b0, b1_beta_reg}) * b1_hi_reg;
    assign part = $signed({{(ACC_W-PROD_W){b1_pa_reg[PROD_W-1]}}, b1_pa_reg})
                + $signed({{(ACC_W-PLO_W){1'b0}}, b1_plo_reg});
    assign acc  = b2_part_reg
                + ($signed({{(ACC_W-PHI_W){b2_phi_reg[PHI_W-1]}}, b2_phi_reg}) <<< LO_W);

    // dropping the low 16 bits rounds toward minus infinity
    assign shifted = b3_acc_reg[ACC_W-1:SH];
    assign fits    = (shifted[SAT_W-1:WEIGHT_W-1] == '0)
                  || (shifted[SAT_W-1:WEIGHT_W-1] == '1);
    assign sat     = fits ? shifted[WEIGHT_W-1:0]
                   : (shifted[SAT_W-1] ? {1'b1, {(WEIGHT_W-1){1'b0}}}
                                       : {1'b0, {(WEIGHT_W-1){1'b1}}});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (rdy[0]) begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (rdy[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            b1_pos_reg  <= in_item.pos;
            b1_pa_reg   <= in_item.pa;
            b1_beta_reg <= in_item.beta;
            b1_hi_reg   <= in_item.val[SUM_W-1:LO_W];
            b1_plo_reg  <= plo;
        end
        if (rdy[1]) begin
            b2_pos_reg  <= b1_pos_reg;
            b2_part_reg <= part;
            b2_phi_reg  <= phi;
        end
        if (rdy[2]) begin
            b3_pos_reg <= b2_pos_reg;
            b3_acc_reg <= acc;
        end
        if (rdy[3]) begin
            pos_reg    <= b3_pos_reg;
            weight_reg <= sat;
        end
    end

    assign out_valid       = v_reg[NST-1];
    assign result_position = pos_reg;
    assign blended_weight  = weight_reg;

endmodule

FILE: hw/rtl/weighted_federated_average_top.sv
// Weighted federated average. Accepts one weight transfer per cycle while s_ready is high,
// node-major: node 0 starts the sum for a position, later nodes add to it, and on the last
// node (node_count - 1) the sum is divided by node_count (toward zero) and blended with the
// start weight as (alpha*start + (1-alpha)*average) >> 16, saturated to 32 bits. Sums live
// in a MAX_WEIGHTS x 38 memory with one registered read and one write per cycle; the write
// from the item just ahead is forwarded, so the same position may come back to back. The sum
// memory needs no clearing pass, but node 0 must come first for each position. Sustained rate
// is one item per cycle while the output is not stalled, set by the memory read-modify-write.
// A result passes two accumulator, seven divider and four blend stages. Positions at or above
// MAX_WEIGHTS are accepted and dropped. The user must write configuration through cfg_* only
// while idle; the block does not enforce it. Depends on wfa_pkg, wfa_acc, wfa_div and wfa_blend.
module weighted_federated_average_top #(
    parameter int MAX_WEIGHTS = 4096
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [wfa_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [wfa_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [wfa_pkg::NODE_W-1:0]           s_node_number,
    input  logic [wfa_pkg::POS_W-1:0]            s_weight_position,
    input  logic signed [wfa_pkg::WEIGHT_W-1:0]  s_node_weight,
    input  logic signed [wfa_pkg::WEIGHT_W-1:0]  s_start_weight,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [wfa_pkg::POS_W-1:0]            m_result_position,
    output logic signed [wfa_pkg::WEIGHT_W-1:0]  m_blended_weight
);

    logic [wfa_pkg::COUNT_W-1:0] node_count_reg;
    logic [wfa_pkg::ALPHA_W-1:0] blend_factor_reg;

    logic               acc_valid;
    logic               acc_ready;
    wfa_pkg::avg_item_t acc_item;
    logic               div_valid;
    logic               div_ready;
    wfa_pkg::avg_item_t div_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg   <= wfa_pkg::COUNT_W'(1);
            blend_factor_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                wfa_pkg::CFG_NODE_COUNT: begin
                    node_count_reg <= cfg_data[wfa_pkg::COUNT_W-1:0];
                end
                wfa_pkg::CFG_BLEND_FACTOR: begin
                    blend_factor_reg <= cfg_data[wfa_pkg::ALPHA_W-1:0];
                end
            endcase
        end
    end

    wfa_acc #(
        .MAX_WEIGHTS (MAX_WEIGHTS)
    ) u_acc (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_node_number     (s_node_number),
        .s_weight_position (s_weight_position),
        .s_node_weight     (s_node_weight),
        .s_start_weight    (s_start_weight),
        .node_count        (node_count_reg),
        .blend_factor      (blend_factor_reg),
        .out_valid         (acc_valid),
        .out_ready         (acc_ready),
        .out_item          (acc_item)
    );

    wfa_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (acc_valid),
        .in_ready  (acc_ready),
        .in_item   (acc_item),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_item  (div_item)
    );

    wfa_blend u_blend (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (div_valid),
        .in_ready        (div_ready),
        .in_item         (div_item),
        .out_valid       (m_valid),
        .out_ready       (m_ready),
        .result_position (m_result_position),
        .blended_weight  (m_blended_weight)
    );

endmodule
